// ===== hdl/xse_pkg.sv =====
// Package for the x86 subset execute unit.
// Holds the item, operation and result types and the flag bit positions.
// Has no dependencies; every other file imports it.
`default_nettype none

package xse_pkg;

  localparam int IDX_W = 4;
  localparam int IP_W = 20;
  localparam int PSIZE_W = 21;
  localparam int FLAGS_W = 9;
  localparam int DATA_W = 16;

  localparam int FLAG_P = 1;
  localparam int FLAG_Z = 3;
  localparam int FLAG_S = 4;

  typedef enum logic [2:0] {
    KIND_MOV = 3'd0,
    KIND_CMP = 3'd1,
    KIND_SUB = 3'd2,
    KIND_ADD = 3'd3,
    KIND_JNE = 3'd4,
    KIND_JE  = 3'd5
  } kind_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic              wide;
    logic [IDX_W-1:0]  dest_reg;
    logic              src_is_imm;
    logic [IDX_W-1:0]  src_reg;
    logic [DATA_W-1:0] imm_value;
    logic signed [7:0] jump_disp;
    logic [2:0]        inst_size;
  } inst_item_t;

  typedef struct packed {
    logic [IP_W-1:0]    next_ip;
    logic [FLAGS_W-1:0] flags;
    logic [DATA_W-1:0]  write_value;
    logic               we;
  } exec_t;

endpackage

`default_nettype wire

// ===== hdl/xse_if.sv =====
// Channel interfaces of the x86 subset execute unit: instruction, result
// and configuration. Each carries valid, ready and its payload.
// Depends on xse_pkg for the field widths.
`default_nettype none

interface xse_inst_if;
  import xse_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic              wide;
  logic [IDX_W-1:0]  dest_reg;
  logic              src_is_imm;
  logic [IDX_W-1:0]  src_reg;
  logic [DATA_W-1:0] imm_value;
  logic signed [7:0] jump_disp;
  logic [2:0]        inst_size;

  modport source (output valid, kind, wide, dest_reg, src_is_imm, src_reg, imm_value,
                  jump_disp, inst_size, input ready);
  modport sink (input valid, kind, wide, dest_reg, src_is_imm, src_reg, imm_value,
                jump_disp, inst_size, output ready);
endinterface

interface xse_res_if;
  import xse_pkg::*;
  logic               valid;
  logic               ready;
  logic [IP_W-1:0]    next_ip;
  logic [FLAGS_W-1:0] flags_out;
  logic [DATA_W-1:0]  write_value;
  logic               done_res;

  modport source (output valid, next_ip, flags_out, write_value, done_res, input ready);
  modport sink (input valid, next_ip, flags_out, write_value, done_res, output ready);
endinterface

interface xse_cfg_if;
  import xse_pkg::*;
  logic               valid;
  logic               ready;
  logic [PSIZE_W-1:0] program_size;

  modport source (output valid, program_size, input ready);
  modport sink (input valid, program_size, output ready);
endinterface

`default_nettype wire

// ===== hdl/x86_subset_execute_unit.sv =====
// Top level of the x86 subset execute unit; uses xse_pkg, the channel
// interfaces, xse_regfile and xse_alu.
// An item is registered into the execute stage, its result into the result
// register. Throughput: one item per cycle while results are taken, set by
// the single execute stage that reads and writes registers, pointer, flags.
// Reset (synchronous, rst high) clears registers, pointer, flags and size.
`default_nettype none

module x86_subset_execute_unit
  import xse_pkg::*;
#(
  parameter int REG_COUNT = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  xse_inst_if.sink   inst,
  xse_res_if.source  res,
  xse_cfg_if.sink    cfg
);

  inst_item_t         in_item;
  inst_item_t         s1_item;
  logic               s1_valid;
  logic               res_valid;
  logic               exec;
  logic               accept;
  logic [IP_W-1:0]    ip;
  logic [FLAGS_W-1:0] flags;
  logic [PSIZE_W-1:0] program_size;
  logic [DATA_W-1:0]  d_full;
  logic [DATA_W-1:0]  s_reg;
  logic               dst_ok;
  exec_t              ex;
  logic [IP_W-1:0]    next_ip;
  logic [FLAGS_W-1:0] flags_out;
  logic [DATA_W-1:0]  write_value;
  logic               done_res;

  assign in_item.kind       = inst.kind;
  assign in_item.wide       = inst.wide;
  assign in_item.dest_reg   = inst.dest_reg;
  assign in_item.src_is_imm = inst.src_is_imm;
  assign in_item.src_reg    = inst.src_reg;
  assign in_item.imm_value  = inst.imm_value;
  assign in_item.jump_disp  = inst.jump_disp;
  assign in_item.inst_size  = inst.inst_size;

  assign exec       = s1_valid && (!res_valid || res.ready);
  assign inst.ready = !s1_valid || exec;
  assign accept     = inst.valid && inst.ready;
  assign cfg.ready  = 1'b1;
  assign dst_ok     = 32'(s1_item.dest_reg) < REG_COUNT;

  xse_regfile #(
    .REG_COUNT(REG_COUNT)
  ) u_regfile (
    .clk     (clk),
    .rst     (rst),
    .re      (accept),
    .raddr_a (inst.dest_reg),
    .raddr_b (inst.src_reg),
    .rdata_a (d_full),
    .rdata_b (s_reg),
    .we      (exec && ex.we),
    .waddr   (s1_item.dest_reg),
    .wdata   (ex.write_value)
  );

  xse_alu u_alu (
    .item   (s1_item),
    .d_full (d_full),
    .s_reg  (s_reg),
    .dst_ok (dst_ok),
    .ip     (ip),
    .flags  (flags),
    .ex     (ex)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (inst.ready) begin
      s1_valid <= inst.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ip    <= '0;
      flags <= '0;
    end else if (exec) begin
      ip    <= ex.next_ip;
      flags <= ex.flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      program_size <= '0;
    end else if (cfg.valid) begin
      program_size <= cfg.program_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (exec) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      next_ip     <= ex.next_ip;
      flags_out   <= ex.flags;
      write_value <= ex.write_value;
      done_res    <= {1'b0, ex.next_ip} >= program_size;
    end
  end

  assign res.valid       = res_valid;
  assign res.next_ip     = next_ip;
  assign res.flags_out   = flags_out;
  assign res.write_value = write_value;
  assign res.done_res    = done_res;

endmodule

`default_nettype wire

// ===== hdl/xse_regfile.sv =====
// Register file with two registered read ports and one write port.
// A write at the same edge as a read of that entry is forwarded; entries
// never written and indexes beyond the file read as zero. Uses xse_pkg.
`default_nettype none

module xse_regfile
  import xse_pkg::*;
#(
  parameter int REG_COUNT = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              re,
  input  wire logic [IDX_W-1:0]  raddr_a,
  input  wire logic [IDX_W-1:0]  raddr_b,
  output logic      [DATA_W-1:0] rdata_a,
  output logic      [DATA_W-1:0] rdata_b,
  input  wire logic              we,
  input  wire logic [IDX_W-1:0]  waddr,
  input  wire logic [DATA_W-1:0] wdata
);

  localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  logic [DATA_W-1:0]    mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld;
  logic [DATA_W-1:0]    rd_a;
  logic [DATA_W-1:0]    rd_b;
  logic                 ok_a;
  logic                 ok_b;
  logic                 hit_a;
  logic                 hit_b;
  logic [DATA_W-1:0]    wd_q;
  logic                 wr_ok;
  logic                 ra_ok;
  logic                 rb_ok;
  logic [AW-1:0]        wa;
  logic [AW-1:0]        ra;
  logic [AW-1:0]        rb;

  assign wa = AW'(waddr);
  assign ra = AW'(raddr_a);
  assign rb = AW'(raddr_b);
  assign wr_ok = we && (32'(waddr) < REG_COUNT);
  assign ra_ok = 32'(raddr_a) < REG_COUNT;
  assign rb_ok = 32'(raddr_b) < REG_COUNT;

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wa] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_ok) begin
      vld[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_a  <= mem[ra];
      rd_b  <= mem[rb];
      ok_a  <= ra_ok && vld[ra];
      ok_b  <= rb_ok && vld[rb];
      hit_a <= wr_ok && ra_ok && (wa == ra);
      hit_b <= wr_ok && rb_ok && (wa == rb);
      wd_q  <= wdata;
    end
  end

  assign rdata_a = hit_a ? wd_q : (ok_a ? rd_a : '0);
  assign rdata_b = hit_b ? wd_q : (ok_b ? rd_b : '0);

endmodule

`default_nettype wire

// ===== hdl/xse_alu.sv =====
// Execute logic for one instruction: operand masking, add and subtract,
// sign, zero and parity flags, pointer advance and conditional jumps.
// Uses the item and result types of xse_pkg.
`default_nettype none

module xse_alu
  import xse_pkg::*;
(
  input  wire inst_item_t         item,
  input  wire logic [DATA_W-1:0]  d_full,
  input  wire logic [DATA_W-1:0]  s_reg,
  input  wire logic               dst_ok,
  input  wire logic [IP_W-1:0]    ip,
  input  wire logic [FLAGS_W-1:0] flags,
  output exec_t                   ex
);

  logic [DATA_W-1:0] d_val;
  logic [DATA_W-1:0] s_raw;
  logic [DATA_W-1:0] s_val;
  logic [DATA_W-1:0] sum;
  logic [DATA_W-1:0] diff;
  logic [DATA_W-1:0] res;
  logic [DATA_W-1:0] merged;
  logic [DATA_W-1:0] merged_mov;
  logic [FLAGS_W-1:0] flags_arith;
  logic [IP_W-1:0]   ip_inc;
  logic [IP_W-1:0]   ip_jmp;
  logic              z_set;

  assign d_val = item.wide ? d_full : {8'h00, d_full[7:0]};
  assign s_raw = item.src_is_imm ? item.imm_value : s_reg;
  assign s_val = item.wide ? s_raw : {8'h00, s_raw[7:0]};
  assign sum   = d_val + s_val;
  assign diff  = d_val - s_val;
  assign ip_inc = ip + IP_W'(item.inst_size);
  assign ip_jmp = ip_inc + IP_W'(item.jump_disp);
  assign z_set  = flags[FLAG_Z];

  always_comb begin
    if (item.kind == KIND_ADD) begin
      res = sum;
    end else begin
      res = diff;
    end
    if (!item.wide) begin
      res[15:8] = 8'h00;
    end
    merged     = item.wide ? res : {d_full[15:8], res[7:0]};
    merged_mov = item.wide ? s_val : {d_full[15:8], s_val[7:0]};
    flags_arith = flags;
    flags_arith[FLAG_S] = item.wide ? res[15] : res[7];
    flags_arith[FLAG_Z] = (res == '0);
    flags_arith[FLAG_P] = ~^res[7:0];
  end

  always_comb begin
    ex.next_ip     = ip_inc;
    ex.flags       = flags;
    ex.write_value = d_full;
    ex.we          = 1'b0;
    unique case (item.kind)
      KIND_MOV: begin
        ex.write_value = merged_mov;
        ex.we          = 1'b1;
      end
      KIND_CMP: begin
        ex.flags = flags_arith;
      end
      KIND_SUB, KIND_ADD: begin
        ex.flags       = flags_arith;
        ex.write_value = merged;
        ex.we          = 1'b1;
      end
      KIND_JNE: begin
        if (!z_set) begin
          ex.next_ip = ip_jmp;
        end
      end
      KIND_JE: begin
        if (z_set) begin
          ex.next_ip = ip_jmp;
        end
      end
      default: begin
      end
    endcase
    if (!dst_ok) begin
      ex.write_value = '0;
      ex.we          = 1'b0;
    end
  end

endmodule

`default_nettype wire
